// ===== design/sle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sorted list engine.
// No dependencies.
package sle_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned POS_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IN_W   = ((2 + DATA_W + POS_W + 7) / 8) * 8;
  localparam int unsigned OUT_W  = ((DATA_W + 3 + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  localparam logic signed [DATA_W-1:0] NOT_FOUND_VALUE = -32'sd1;

  // Command broadcast to every cell for one word.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== design/sorted_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Sorted list engine: a chain of DEPTH cells kept in ascending order.
// Result word: registered, presented in the cycle after the input word is taken.
// Throughput: one word per cycle unless m_axis_tready holds a result; each cell compares and shifts in parallel.
// Reset (rst, synchronous): count cleared, output empty; cell contents kept.
// Depends on sle_pkg and sle_cell.
module sorted_list_engine_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [sle_pkg::IN_W-1:0]  s_axis_tdata,  // op, value, position
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [sle_pkg::OUT_W-1:0] m_axis_tdata   // read_value, found, status, entry_count
);

  localparam int unsigned DEPTH = sle_pkg::DEPTH;
  localparam int unsigned PW    = sle_pkg::POS_W;
  localparam int unsigned CW    = sle_pkg::CNT_W;
  localparam int unsigned OUT_W = sle_pkg::OUT_W;
  localparam int unsigned DW    = sle_pkg::DATA_W;

  sle_pkg::op_t               op;
  logic signed [DW-1:0]       in_value;
  logic [PW-1:0]              position;
  logic                       in_acc;

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic signed [DW-1:0]       read_value;
  logic signed [DW-1:0]       read_value_next;
  logic                       found;
  logic                       found_next;
  sle_pkg::status_t           status;
  sle_pkg::status_t           status_next;
  logic [CW-1:0]              entry_count;

  logic                       full;
  logic                       in_range;
  sle_pkg::cell_cmd_t         cmd;
  logic                       cell_flag  [DEPTH];
  logic signed [DW-1:0]       cell_value [DEPTH];
  logic signed [DW-1:0]       masked     [DEPTH];
  logic signed [DW-1:0]       picked;

  assign op       = sle_pkg::op_t'(s_axis_tdata[1:0]);
  assign in_value = s_axis_tdata[DW+1:2];
  assign position = s_axis_tdata[DW+PW+1:DW+2];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign full     = (count == CW'(DEPTH));
  assign in_range = (CW'(position) < count);

  assign cmd.ins   = in_acc && (op == sle_pkg::OP_INSERT) && !full;
  assign cmd.rem   = in_acc && (op == sle_pkg::OP_REMOVE) && in_range;
  assign cmd.value = in_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 lf;
    logic signed [DW-1:0] lv;
    logic signed [DW-1:0] rv;
    if (i == 0) begin : g_first
      assign lf = 1'b0;
      assign lv = cell_value[i];
    end else begin : g_inner
      assign lf = cell_flag[i-1];
      assign lv = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = cell_value[i];
    end else begin : g_mid
      assign rv = cell_value[i+1];
    end

    sle_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CW'(i) < count),
      .from_pos    (PW'(i) >= position),
      .left_flag   (lf),
      .left_value  (lv),
      .right_value (rv),
      .flag        (cell_flag[i]),
      .value       (cell_value[i])
    );

    assign masked[i] = (PW'(i) == position) ? cell_value[i] : '0;
  end

  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | masked[i];
    end
  end

  always_comb begin
    count_next      = count;
    read_value_next = '0;
    found_next      = 1'b0;
    status_next     = sle_pkg::ST_OK;
    unique case (op)
      sle_pkg::OP_INSERT: begin
        if (full) begin
          status_next = sle_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      sle_pkg::OP_READ: begin
        if (in_range) begin
          read_value_next = picked;
          found_next      = 1'b1;
        end else begin
          read_value_next = sle_pkg::NOT_FOUND_VALUE;
          status_next     = sle_pkg::ST_RANGE;
        end
      end
      sle_pkg::OP_REMOVE: begin
        if (in_range) begin
          count_next = count - CW'(1);
          found_next = 1'b1;
        end else begin
          status_next = sle_pkg::ST_RANGE;
        end
      end
      sle_pkg::OP_CLEAR: begin
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_acc) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      read_value  <= read_value_next;
      found       <= found_next;
      status      <= status_next;
      entry_count <= count_next;
    end
  end

  assign m_axis_tdata = OUT_W'({entry_count, status, found, read_value});

  // Checks

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> m_axis_tvalid)
    else $error("accepted word gave no result");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && found) |-> (status == sle_pkg::ST_OK))
    else $error("found result with error status");

endmodule

// ===== design/sle_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one entry, compares it with the
// value being inserted and shifts with its neighbours. Uses sle_pkg.
module sle_cell (
  input  logic                                 clk,
  input  sle_pkg::cell_cmd_t                   cmd,
  input  logic                                 occupied,
  input  logic                                 from_pos,
  input  logic                                 left_flag,
  input  logic signed [sle_pkg::DATA_W-1:0]    left_value,
  input  logic signed [sle_pkg::DATA_W-1:0]    right_value,
  output logic                                 flag,
  output logic signed [sle_pkg::DATA_W-1:0]    value
);

  // Set at and beyond the insertion point.
  assign flag = !occupied || ($signed(value) > $signed(cmd.value));

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (flag && !left_flag) begin
        value <= cmd.value;
      end else if (flag) begin
        value <= left_value;
      end
    end else if (cmd.rem && from_pos) begin
      value <= right_value;
    end
  end

endmodule
